/* rtl/lsbc_pkg.sv */
// shared types and constants for the sector block cache
// field widths, command and status codes, fsm states, cell chain structs
// no dependencies
`default_nettype none

package lsbc_pkg;

   // field widths of the request and response channels
   localparam int TAG_W        = 32;
   localparam int CMD_W        = 2;
   localparam int COUNT_W      = 8;
   localparam int WIDX_W       = 6;
   localparam int DATA_W       = 64;
   localparam int STATUS_W     = 2;
   localparam int SLOT_FIELD_W = 3;

   // request commands
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

   // largest block count served in one request
   localparam logic [COUNT_W-1:0] MAX_COUNT = 8'd1;

   // control states
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_EMIT   = 4'b0100,
      S_STREAM = 4'b1000
   } state_type;

   // lookup token moving down the cell chain
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [TAG_W-1:0] tag;
   } tok_type;

   // broadcast update applied to every cell at the end of a lookup
   typedef struct packed {
      logic             valid;
      logic             tag_wr;
      logic [TAG_W-1:0] tag;
   } upd_type;

endpackage

`default_nettype wire

/* rtl/lsbc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lsbc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, output holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/lsbc_cell.sv */
// one cache slot: tag, valid bit and recency rank, plus one stage of the lookup chain
// depends on lsbc_pkg
`default_nettype none

module lsbc_cell #(
   parameter int ENTRIES = 8,
   parameter int IDX     = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // lookup token from the upstream neighbor
   input  wire lsbc_pkg::tok_type             up_tok,
   input  wire logic [$clog2(ENTRIES)-1:0]    up_hit_slot,
   input  wire logic [$clog2(ENTRIES)-1:0]    up_hit_rank,
   input  wire logic [$clog2(ENTRIES)-1:0]    up_lru_slot,
   // lookup token to the downstream neighbor
   output lsbc_pkg::tok_type                  dn_tok,
   output logic      [$clog2(ENTRIES)-1:0]    dn_hit_slot,
   output logic      [$clog2(ENTRIES)-1:0]    dn_hit_rank,
   output logic      [$clog2(ENTRIES)-1:0]    dn_lru_slot,
   // broadcast update
   input  wire lsbc_pkg::upd_type             upd,
   input  wire logic [$clog2(ENTRIES)-1:0]    upd_slot,
   input  wire logic [$clog2(ENTRIES)-1:0]    upd_rank
);

   import lsbc_pkg::*;

   localparam int                SLOT_W    = $clog2(ENTRIES);
   localparam logic [SLOT_W-1:0] MY_SLOT   = SLOT_W'(IDX);
   localparam logic [SLOT_W-1:0] LAST_RANK = SLOT_W'(ENTRIES - 1);

   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              valid_ff, valid_in;
   logic [SLOT_W-1:0] rank_ff, rank_in;

   tok_type           dn_tok_ff, dn_tok_in;
   logic [SLOT_W-1:0] dn_hit_slot_ff, dn_hit_slot_in;
   logic [SLOT_W-1:0] dn_hit_rank_ff, dn_hit_rank_in;
   logic [SLOT_W-1:0] dn_lru_slot_ff, dn_lru_slot_in;

   logic match;
   logic first_hit;

   // compare against the passing token and fold in this slot
   always_comb begin
      match          = valid_ff && (tag_ff == up_tok.tag);
      first_hit      = match && !up_tok.hit;
      dn_tok_in      = up_tok;
      dn_tok_in.hit  = up_tok.hit || match;
      dn_hit_slot_in = first_hit ? MY_SLOT : up_hit_slot;
      dn_hit_rank_in = first_hit ? rank_ff : up_hit_rank;
      dn_lru_slot_in = (rank_ff == LAST_RANK) ? MY_SLOT : up_lru_slot;
   end

   // slot update: chosen slot becomes most recent (and takes a new tag when written), younger slots age by one
   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.valid) begin
         if (upd_slot == MY_SLOT) begin
            rank_in = '0;
            if (upd.tag_wr) begin
               tag_in   = upd.tag;
               valid_in = 1'b1;
            end
         end else if (rank_ff < upd_rank) begin
            rank_in = rank_ff + SLOT_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         rank_ff   <= MY_SLOT;
         dn_tok_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         rank_ff   <= rank_in;
         dn_tok_ff <= dn_tok_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      tag_ff         <= tag_in;
      dn_hit_slot_ff <= dn_hit_slot_in;
      dn_hit_rank_ff <= dn_hit_rank_in;
      dn_lru_slot_ff <= dn_lru_slot_in;
   end

   assign dn_tok      = dn_tok_ff;
   assign dn_hit_slot = dn_hit_slot_ff;
   assign dn_hit_rank = dn_hit_rank_ff;
   assign dn_lru_slot = dn_lru_slot_ff;

endmodule

`default_nettype wire

/* rtl/lru_sector_block_cache.sv */
// Fully associative sector block cache, LRU replacement, one cell per slot.
// Continuation word of an open write: result registered at the accepting edge, one transfer
// per cycle while the response side keeps up. Lookup (read, first word of create/update):
// token crosses one cell per cycle, decided at the chain end; input stalled until the result
// is registered. Read hit: words pass the block ram read register and the output register,
// one word per cycle while the response side keeps up, input stalled to the last word.
// Reset (synchronous): valid bits cleared, ranks set to slot order, write closed.
`default_nettype none

module lru_sector_block_cache #(
   parameter int ENTRIES         = 8,
   parameter int WORDS_PER_BLOCK = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lsbc_pkg::CMD_W-1:0]          req_command,
   input  wire logic [lsbc_pkg::TAG_W-1:0]          req_sector_address,
   input  wire logic [lsbc_pkg::COUNT_W-1:0]        req_block_count,
   input  wire logic [lsbc_pkg::WIDX_W-1:0]         req_word_index,
   input  wire logic [lsbc_pkg::DATA_W-1:0]         req_data_word,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [lsbc_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [lsbc_pkg::DATA_W-1:0]         rsp_data_word_res,
   output logic      [lsbc_pkg::SLOT_FIELD_W-1:0]   rsp_slot,
   output logic                                     rsp_last
);

   import lsbc_pkg::*;

   localparam int                SLOT_W    = $clog2(ENTRIES);
   localparam int                DEPTH     = ENTRIES * WORDS_PER_BLOCK;
   localparam int                ADDR_W    = $clog2(DEPTH);
   localparam logic [SLOT_W-1:0] LRU_RANK  = SLOT_W'(ENTRIES - 1);
   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS_PER_BLOCK - 1);
   localparam logic [WIDX_W:0]   WPB_EXT   = (WIDX_W + 1)'(WORDS_PER_BLOCK);
   localparam logic              WPB_ONE   = (WORDS_PER_BLOCK == 1);

   // block ram address of a word within a slot
   function automatic logic [ADDR_W-1:0] blk_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [WIDX_W-1:0] w);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(s) * ADDR_W'(WORDS_PER_BLOCK);
      return base + ADDR_W'(w);
   endfunction

   // control state
   state_type         state_ff, state_in;
   logic              write_en_ff, write_en_in;
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;

   // request held through a lookup
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [DATA_W-1:0] data_ff, data_in;

   // pending single result
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic                pend_last_ff, pend_last_in;

   // block streaming
   logic [SLOT_W-1:0] stream_slot_ff, stream_slot_in;
   logic [WIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [WIDX_W-1:0] del_idx_ff, del_idx_in;
   logic              issue_done_ff, issue_done_in;
   logic              data_avail_ff, data_avail_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                    rsp_last_ff, rsp_last_in;

   // cell chain
   tok_type           chain_tok      [ENTRIES+1];
   logic [SLOT_W-1:0] chain_hit_slot [ENTRIES+1];
   logic [SLOT_W-1:0] chain_hit_rank [ENTRIES+1];
   logic [SLOT_W-1:0] chain_lru_slot [ENTRIES+1];
   upd_type           upd;
   logic [SLOT_W-1:0] upd_rank;

   // block ram ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [DATA_W-1:0] ram_rd_data;

   // decode and handshake
   logic req_xfer, out_free;
   logic req_reject, req_is_read, req_is_write, req_widx_zero, req_beyond, req_last_word;
   logic need_search, cont_ok;
   logic srch_done, end_hit, ff_is_read, write_take;
   logic [SLOT_W-1:0] sel_slot;
   logic stream_move, rd_issue, del_last;

   // single result source
   logic                res_load;
   logic [STATUS_W-1:0] res_status;
   logic [SLOT_W-1:0]   res_slot;
   logic                res_last;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // request decode
   always_comb begin
      req_reject    = (req_block_count > MAX_COUNT) || (req_command == CMD_RESERVED);
      req_is_read   = (req_command == CMD_READ);
      req_is_write  = (req_command == CMD_CREATE) || (req_command == CMD_UPDATE);
      req_widx_zero = (req_word_index == '0);
      req_beyond    = ({1'b0, req_word_index} >= WPB_EXT);
      req_last_word = (req_word_index == LAST_WORD);
      need_search   = !req_reject && (req_is_read || req_widx_zero);
      cont_ok       = !req_reject && req_is_write && !req_widx_zero && write_en_ff
                      && !req_beyond;
   end

   // lookup results at the chain end
   always_comb begin
      srch_done  = (state_ff == S_SEARCH) && chain_tok[ENTRIES].valid;
      end_hit    = chain_tok[ENTRIES].hit;
      ff_is_read = (cmd_ff == CMD_READ);
      write_take = end_hit || (cmd_ff == CMD_CREATE);
      sel_slot   = end_hit ? chain_hit_slot[ENTRIES] : chain_lru_slot[ENTRIES];
      upd_rank   = end_hit ? chain_hit_rank[ENTRIES] : LRU_RANK;
   end

   // token enters the first cell on a lookup transfer
   assign chain_tok[0].valid = req_xfer && need_search;
   assign chain_tok[0].hit   = 1'b0;
   assign chain_tok[0].tag   = req_sector_address;
   assign chain_hit_slot[0]  = '0;
   assign chain_hit_rank[0]  = '0;
   assign chain_lru_slot[0]  = '0;

   // one cell per slot
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lsbc_cell #(
         .ENTRIES (ENTRIES),
         .IDX     (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .up_tok      (chain_tok[g]),
         .up_hit_slot (chain_hit_slot[g]),
         .up_hit_rank (chain_hit_rank[g]),
         .up_lru_slot (chain_lru_slot[g]),
         .dn_tok      (chain_tok[g+1]),
         .dn_hit_slot (chain_hit_slot[g+1]),
         .dn_hit_rank (chain_hit_rank[g+1]),
         .dn_lru_slot (chain_lru_slot[g+1]),
         .upd         (upd),
         .upd_slot    (sel_slot),
         .upd_rank    (upd_rank)
      );
   end

   // main sequencer
   always_comb begin
      state_in      = state_ff;
      write_en_in   = write_en_ff;
      write_slot_in = write_slot_ff;
      res_load      = 1'b0;
      res_status    = ST_DONE;
      res_slot      = '0;
      res_last      = 1'b0;
      ram_we        = 1'b0;
      ram_wr_addr   = blk_addr(write_slot_ff, req_word_index);
      ram_wr_data   = req_data_word;
      upd           = '0;
      upd.tag       = tag_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (need_search) begin
                  state_in = S_SEARCH;
                  if (req_is_read) begin
                     write_en_in = 1'b0;
                  end
               end else begin
                  res_load = 1'b1;
                  if (!out_free) begin
                     state_in = S_EMIT;
                  end
                  if (req_reject) begin
                     res_status = ST_REJECT;
                     res_last   = 1'b1;
                  end else if (cont_ok) begin
                     // continuation word of an open write
                     ram_we   = 1'b1;
                     res_slot = write_slot_ff;
                     res_last = req_last_word;
                     if (req_last_word) begin
                        write_en_in = 1'b0;
                     end
                  end else begin
                     // no open write, or index past the block
                     res_status  = ST_MISS;
                     res_last    = 1'b1;
                     write_en_in = 1'b0;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (srch_done) begin
               if (ff_is_read && end_hit) begin
                  upd.valid = 1'b1;
                  state_in  = S_STREAM;
               end else begin
                  res_load   = 1'b1;
                  res_status = ST_MISS;
                  res_last   = 1'b1;
                  state_in   = out_free ? S_IDLE : S_EMIT;
                  if (!ff_is_read) begin
                     if (write_take) begin
                        // first word: hit slot, or the lru slot on a create miss
                        upd.valid     = 1'b1;
                        upd.tag_wr    = !end_hit;
                        ram_we        = 1'b1;
                        ram_wr_addr   = blk_addr(sel_slot, '0);
                        ram_wr_data   = data_ff;
                        write_slot_in = sel_slot;
                        write_en_in   = !WPB_ONE;
                        res_status    = ST_DONE;
                        res_slot      = sel_slot;
                        res_last      = WPB_ONE;
                     end else begin
                        write_en_in = 1'b0;
                     end
                  end
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_STREAM: begin
            if (stream_move && del_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // held request and pending result
   always_comb begin
      cmd_in         = req_xfer ? req_command : cmd_ff;
      tag_in         = req_xfer ? req_sector_address : tag_ff;
      data_in        = req_xfer ? req_data_word : data_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_last_in   = pend_last_ff;
      if (res_load && !out_free) begin
         pend_status_in = res_status;
         pend_slot_in   = res_slot;
         pend_last_in   = res_last;
      end
   end

   // block read streaming, one word in flight in the ram output register
   always_comb begin
      stream_move    = (state_ff == S_STREAM) && data_avail_ff && out_free;
      rd_issue       = (state_ff == S_STREAM) && !issue_done_ff
                       && (!data_avail_ff || out_free);
      del_last       = (del_idx_ff == LAST_WORD);
      stream_slot_in = stream_slot_ff;
      rd_idx_in      = rd_idx_ff;
      del_idx_in     = del_idx_ff;
      issue_done_in  = issue_done_ff;
      data_avail_in  = data_avail_ff;
      if (srch_done) begin
         stream_slot_in = chain_hit_slot[ENTRIES];
         rd_idx_in      = '0;
         del_idx_in     = '0;
         issue_done_in  = 1'b0;
         data_avail_in  = 1'b0;
      end else begin
         if (rd_issue) begin
            rd_idx_in     = rd_idx_ff + WIDX_W'(1);
            issue_done_in = (rd_idx_ff == LAST_WORD);
            data_avail_in = 1'b1;
         end else if (stream_move) begin
            data_avail_in = 1'b0;
         end
         if (stream_move) begin
            del_idx_in = del_idx_ff + WIDX_W'(1);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      if (stream_move) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_DONE;
         rsp_data_in   = ram_rd_data;
         rsp_slot_in   = SLOT_FIELD_W'(stream_slot_ff);
         rsp_last_in   = del_last;
      end else if ((state_ff == S_EMIT) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_data_in   = '0;
         rsp_slot_in   = SLOT_FIELD_W'(pend_slot_ff);
         rsp_last_in   = pend_last_ff;
      end else if (res_load && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_data_in   = '0;
         rsp_slot_in   = SLOT_FIELD_W'(res_slot);
         rsp_last_in   = res_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         write_en_ff   <= 1'b0;
         write_slot_ff <= '0;
         data_avail_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_en_ff   <= write_en_in;
         write_slot_ff <= write_slot_in;
         data_avail_ff <= data_avail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      tag_ff         <= tag_in;
      data_ff        <= data_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_last_ff   <= pend_last_in;
      stream_slot_ff <= stream_slot_in;
      rd_idx_ff      <= rd_idx_in;
      del_idx_ff     <= del_idx_in;
      issue_done_ff  <= issue_done_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // block data store
   lsbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_issue),
      .rd_addr (blk_addr(stream_slot_ff, rd_idx_ff)),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_data_word_res = rsp_data_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/lsbc_checker.sv */
// port-level checks on the response channel of the sector block cache
// depends on lsbc_pkg; bound to lru_sector_block_cache
`default_nettype none

module lsbc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [lsbc_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic [lsbc_pkg::DATA_W-1:0]         rsp_data_word_res,
   input wire logic [lsbc_pkg::SLOT_FIELD_W-1:0]   rsp_slot,
   input wire logic                                rsp_last
);

   import lsbc_pkg::*;

   // a stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_word_res) && $stable(rsp_slot) && $stable(rsp_last))
      else $error("response changed while stalled");

   // nothing pending after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // miss and reject are single-result requests with no data
   a_short_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_REJECT)
         |-> rsp_last && (rsp_data_word_res == '0))
      else $error("miss or reject not a single empty result");

   // miss and reject carry no slot
   a_short_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_REJECT)
         |-> (rsp_slot == '0))
      else $error("miss or reject with a slot number");

endmodule

bind lru_sector_block_cache lsbc_checker u_lsbc_checker (.*);

`default_nettype wire
